[rtl/ile_pkg.sv]
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and constants for the indexed list engine: list geometry,
// command and status codes, and the control word broadcast along the cells.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  // fixed port widths
  localparam int CMD_W  = 4;
  localparam int IN_W   = 32;
  localparam int IDX_W  = 5;
  localparam int OUT_W  = 32;
  localparam int ST_W   = 2;

  // derived widths
  localparam int PTR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_FRONT  = 4'd0,
    CMD_ADD_BACK   = 4'd1,
    CMD_INSERT     = 4'd2,
    CMD_TAKE_FRONT = 4'd3,
    CMD_TAKE_BACK  = 4'd4,
    CMD_REMOVE     = 4'd5,
    CMD_CLEAR      = 4'd6,
    CMD_READ_FRONT = 4'd7,
    CMD_READ_BACK  = 4'd8,
    CMD_READ_AT    = 4'd9
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e              op;
    logic [PTR_W-1:0]      pos;
    logic [DATA_WIDTH-1:0] data;
  } cell_ctrl_t;

endpackage

[rtl/ile_cell.sv]
// ----------------------------------------------------------------------------
// ile_cell
// One list slot. On insert, cells past the position take the left neighbor and
// the cell at it the new word; on remove, cells from it on take the right one.
// ----------------------------------------------------------------------------
module ile_cell
  import ile_pkg::*;
(
  input  logic                  clk_i,
  input  logic [PTR_W-1:0]      cell_idx_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] value_o
);

  logic [DATA_WIDTH-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (cell_idx_i == ctrl_i.pos) begin
          value_d = ctrl_i.data;
        end else if (cell_idx_i > ctrl_i.pos) begin
          value_d = left_i;
        end
      end
      OP_REMOVE: begin
        if (cell_idx_i >= ctrl_i.pos) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

[rtl/ile_chain.sv]
// ----------------------------------------------------------------------------
// ile_chain
// Row of CAPACITY cells linked to their neighbors, with a read select that
// picks one cell for the read commands.
// ----------------------------------------------------------------------------
module ile_chain
  import ile_pkg::*;
(
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [PTR_W-1:0]      rd_pos_i,
  output logic [DATA_WIDTH-1:0] rd_data_o
);

  logic [DATA_WIDTH-1:0] value [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;

    // the front has no left neighbor; the back keeps its own word on remove
    if (i == 0) begin : g_front
      assign left = ctrl_i.data;
    end else begin : g_inner_l
      assign left = value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_back
      assign right = value[i];
    end else begin : g_inner_r
      assign right = value[i+1];
    end

    ile_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (PTR_W'(i)),
      .ctrl_i     (ctrl_i),
      .left_i     (left),
      .right_i    (right),
      .value_o    (value[i])
    );
  end

  assign rd_data_o = value[rd_pos_i];

endmodule

[rtl/indexed_list_engine.sv]
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of up to CAPACITY words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// No command stalls: busy_o stays low, so a command may be issued
// on every clock. The result of a command accepted at one edge appears on the
// result ports in the next cycle, marked by done_o for exactly that cycle, and
// the receiver must take it then. Insert and remove move all later cells by
// one place in that same cycle; the read select over the cell row is the
// longest path. read_data_o is zero for all but a successful read, and count_o
// is the element count after the command.
module indexed_list_engine
  import ile_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [CMD_W-1:0] command_i,
  input  logic [IN_W-1:0]  data_i,
  input  logic [IDX_W-1:0] index_i,
  output logic             done_o,
  output logic [OUT_W-1:0] read_data_o,
  output logic [CNT_W-1:0] count_o,
  output logic [ST_W-1:0]  status_o
);

  logic                  accept;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  done_q;
  logic [OUT_W-1:0]      rd_q, rd_d;
  status_e               status_q, status_d;
  cell_ctrl_t            ctrl;
  logic [PTR_W-1:0]      rd_pos;
  logic [DATA_WIDTH-1:0] rd_cell;
  logic [CMP_W-1:0]      idx_ext, cnt_ext;
  logic                  is_empty, is_full;
  logic [PTR_W-1:0]      last_pos;
  logic [63:0]           rd_wide;

  assign busy_o   = 1'b0;
  assign accept   = start_i;
  assign idx_ext  = CMP_W'(index_i);
  assign cnt_ext  = CMP_W'(count_q);
  assign is_empty = (count_q == '0);
  assign is_full  = (cnt_ext == CMP_W'(CAPACITY));
  assign last_pos = PTR_W'(count_q - CNT_W'(1));
  assign rd_wide  = 64'(rd_cell);

  always_comb begin
    ctrl      = '{op: OP_HOLD, pos: '0, data: DATA_WIDTH'(data_i)};
    rd_pos    = '0;
    rd_d      = '0;
    status_d  = ST_OK;
    count_d   = count_q;
    if (accept) begin
      case (command_i)
        CMD_ADD_FRONT, CMD_ADD_BACK, CMD_INSERT: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else if (command_i == CMD_INSERT && idx_ext > cnt_ext) begin
            status_d = ST_RANGE;
          end else begin
            ctrl.op = OP_INSERT;
            case (command_i)
              CMD_ADD_FRONT: ctrl.pos = '0;
              CMD_ADD_BACK:  ctrl.pos = PTR_W'(count_q);
              default:       ctrl.pos = PTR_W'(idx_ext);
            endcase
            count_d = count_q + CNT_W'(1);
          end
        end
        CMD_TAKE_FRONT, CMD_TAKE_BACK, CMD_REMOVE: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else if (command_i == CMD_REMOVE && idx_ext >= cnt_ext) begin
            status_d = ST_RANGE;
          end else begin
            ctrl.op = OP_REMOVE;
            case (command_i)
              CMD_TAKE_FRONT: ctrl.pos = '0;
              CMD_TAKE_BACK:  ctrl.pos = last_pos;
              default:        ctrl.pos = PTR_W'(idx_ext);
            endcase
            count_d = count_q - CNT_W'(1);
          end
        end
        CMD_CLEAR: count_d = '0;
        CMD_READ_FRONT, CMD_READ_BACK, CMD_READ_AT: begin
          case (command_i)
            CMD_READ_FRONT: rd_pos = '0;
            CMD_READ_BACK:  rd_pos = last_pos;
            default:        rd_pos = PTR_W'(idx_ext);
          endcase
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else if (command_i == CMD_READ_AT && idx_ext >= cnt_ext) begin
            status_d = ST_RANGE;
          end else begin
            rd_d = rd_wide[OUT_W-1:0];
          end
        end
        default: status_d = ST_OK;
      endcase
    end
  end

  ile_chain u_chain (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .rd_pos_i  (rd_pos),
    .rd_data_o (rd_cell)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      count_q  <= count_d;
      done_q   <= accept;
      status_q <= status_d;
    end
  end

  // result payload; qualified by done_q
  always_ff @(posedge clk_i) begin
    rd_q <= rd_d;
  end

  assign done_o      = done_q;
  assign read_data_o = rd_q;
  assign count_o     = count_q;
  assign status_o    = status_q;

endmodule

[tb/sv/indexed_list_engine_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine_tb
// Self-checking bench for the indexed list engine. A short table of commands
// walks the empty, single-element and full corners. Random command mixes
// then grow, drain and churn the list. Every transfer is scored against a
// behavioral copy of the list kept here, or against the row's typed-in reply.
// ----------------------------------------------------------------------------
module indexed_list_engine_tb;
  import ile_pkg::*;

  localparam int RANDOM_ITEMS = 1900;
  localparam int TIMEOUT_NS   = 100_000;
  localparam int DRAIN_LIMIT  = 200;
  localparam int PRINT_LIMIT  = 40;
  localparam int OWED_DEPTH   = 16;

  // commands past the last defined one are ignored by the block
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_W'(int'(CMD_READ_AT) + 1);
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;

  typedef struct {
    logic [OUT_W-1:0] rd;
    logic [CNT_W-1:0] cnt;
    status_e          st;
  } list_reply_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [IN_W-1:0]  data;
    logic [IDX_W-1:0] idx;
    int               reps;
    bit               fixed;
    logic [OUT_W-1:0] rd;
    logic [CNT_W-1:0] cnt;
    status_e          st;
  } plan_row_t;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             start_i   = 1'b0;
  logic [CMD_W-1:0] command_i = '0;
  logic [IN_W-1:0]  data_i    = '0;
  logic [IDX_W-1:0] index_i   = '0;
  logic             busy_o;
  logic             done_o;
  logic [OUT_W-1:0] read_data_o;
  logic [CNT_W-1:0] count_o;
  logic [ST_W-1:0]  status_o;

  // typed-in expectation that travels with a table row
  bit               row_fixed = 1'b0;
  list_reply_t      row_reply;

  logic [DATA_WIDTH-1:0] shadow_cells [CAPACITY];
  int                    shadow_len = 0;
  // ring of replies owed by the block, scored in order
  list_reply_t           owed_ring [OWED_DEPTH];
  int                    owed_head = 0;
  int                    owed_tail = 0;
  int                    mismatches = 0;
  bit                    allow_idle = 1'b1;

  always #1 clk_i = ~clk_i;

  indexed_list_engine u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .command_i   (command_i),
    .data_i      (data_i),
    .index_i     (index_i),
    .done_o      (done_o),
    .read_data_o (read_data_o),
    .count_o     (count_o),
    .status_o    (status_o)
  );

  task automatic flag_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Apply one command to the shadow list and return the reply it owes.
  function automatic list_reply_t list_apply(input logic [CMD_W-1:0] cmd,
                                             input logic [IN_W-1:0]  data,
                                             input logic [IDX_W-1:0] idx);
    list_reply_t r;
    int n;
    int pos;
    r.rd  = '0;
    r.st  = ST_OK;
    n     = shadow_len;
    pos   = int'(idx);
    case (cmd)
      CMD_ADD_FRONT, CMD_ADD_BACK, CMD_INSERT: begin
        if (n >= CAPACITY) begin
          r.st = ST_FULL;
        end else if (cmd == CMD_INSERT && pos > n) begin
          r.st = ST_RANGE;
        end else begin
          if (cmd == CMD_ADD_FRONT) pos = 0;
          else if (cmd == CMD_ADD_BACK) pos = n;
          for (int i = n; i > pos; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[pos] = data[DATA_WIDTH-1:0];
          shadow_len = n + 1;
        end
      end
      CMD_TAKE_FRONT, CMD_TAKE_BACK, CMD_REMOVE: begin
        if (n == 0) begin
          r.st = ST_EMPTY;
        end else if (cmd == CMD_REMOVE && pos >= n) begin
          r.st = ST_RANGE;
        end else begin
          if (cmd == CMD_TAKE_FRONT) pos = 0;
          else if (cmd == CMD_TAKE_BACK) pos = n - 1;
          for (int i = pos; i + 1 < n; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_len = n - 1;
        end
      end
      CMD_CLEAR: shadow_len = 0;
      CMD_READ_FRONT, CMD_READ_BACK, CMD_READ_AT: begin
        if (n == 0) begin
          r.st = ST_EMPTY;
        end else if (cmd == CMD_READ_AT && pos >= n) begin
          r.st = ST_RANGE;
        end else begin
          if (cmd == CMD_READ_FRONT) pos = 0;
          else if (cmd == CMD_READ_BACK) pos = n - 1;
          r.rd = OUT_W'(shadow_cells[pos]);
        end
      end
      default: ;
    endcase
    r.cnt = CNT_W'(shadow_len);
    return r;
  endfunction

  // Score the reply in flight, then log the command taken at this edge.
  always @(posedge clk_i) begin : scoreboard
    list_reply_t want;
    list_reply_t fresh;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (owed_tail == owed_head) begin
          flag_mismatch("reply with no command outstanding");
        end else begin
          want = owed_ring[owed_head % OWED_DEPTH];
          owed_head++;
          if (read_data_o !== want.rd)
            flag_mismatch($sformatf("read_data %h, want %h", read_data_o, want.rd));
          if (count_o !== want.cnt)
            flag_mismatch($sformatf("count %0d, want %0d", count_o, want.cnt));
          if (status_o !== want.st)
            flag_mismatch($sformatf("status %0d, want %s", status_o, want.st.name()));
        end
      end else if (done_o !== 1'b0) begin
        flag_mismatch("done_o unknown");
      end
      if (start_i && busy_o === 1'b0) begin
        fresh = list_apply(command_i, data_i, index_i);
        if (row_fixed) fresh = row_reply;
        owed_ring[owed_tail % OWED_DEPTH] = fresh;
        owed_tail++;
      end
    end
  end

  // Hold a command until the block takes it; idle at random beforehand.
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [IN_W-1:0] data,
                       input logic [IDX_W-1:0] idx, input bit fixed,
                       input list_reply_t reply);
    while (allow_idle && $urandom_range(0, 99) < 16) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i   <= 1'b1;
    command_i <= cmd;
    data_i    <= data;
    index_i   <= idx;
    row_fixed <= fixed;
    row_reply <= reply;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
  endtask

  // Stop sending and wait for every owed reply; drop what never shows up.
  task automatic drain;
    int guard;
    guard = 0;
    start_i <= 1'b0;
    @(posedge clk_i);
    while (owed_tail != owed_head && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    while (owed_tail != owed_head) begin
      owed_head++;
      flag_mismatch("reply never arrived");
    end
  endtask

  plan_row_t plan [29] = '{
    '{CMD_READ_FRONT, 32'h0,         5'd0,  1,  1'b1, 32'h0, 5'd0,  ST_EMPTY},
    '{CMD_TAKE_BACK,  32'h0,         5'd0,  1,  1'b1, 32'h0, 5'd0,  ST_EMPTY},
    '{CMD_REMOVE,     32'h0,         5'd0,  1,  1'b1, 32'h0, 5'd0,  ST_EMPTY},
    '{CMD_READ_AT,    32'h0,         5'd0,  1,  1'b1, 32'h0, 5'd0,  ST_EMPTY},
    '{CMD_INSERT,     32'hDEAD_BEEF, 5'd1,  1,  1'b1, 32'h0, 5'd0,  ST_RANGE},
    '{CMD_INSERT,     32'hFFFF_FFFF, 5'd0,  1,  1'b1, 32'h0, 5'd1,  ST_OK},
    '{CMD_TAKE_BACK,  32'h0,         5'd0,  1,  1'b1, 32'h0, 5'd0,  ST_OK},
    '{CMD_ADD_BACK,   32'h0,         5'd0,  1,  1'b1, 32'h0, 5'd1,  ST_OK},
    '{CMD_ADD_FRONT,  32'hFFFF_FFFF, 5'd0,  1,  1'b1, 32'h0, 5'd2,  ST_OK},
    '{CMD_INSERT,     32'h8000_0001, 5'd2,  1,  1'b1, 32'h0, 5'd3,  ST_OK},
    '{CMD_READ_BACK,  32'h0,         5'd0,  1,  1'b0, 32'h0, 5'd0,  ST_OK},
    '{CMD_READ_AT,    32'h0,         5'd3,  1,  1'b1, 32'h0, 5'd3,  ST_RANGE},
    '{CMD_REMOVE,     32'h0,         5'd3,  1,  1'b1, 32'h0, 5'd3,  ST_RANGE},
    '{CMD_READ_AT,    32'h0,         5'd1,  1,  1'b0, 32'h0, 5'd0,  ST_OK},
    '{CMD_REMOVE,     32'h0,         5'd1,  1,  1'b0, 32'h0, 5'd0,  ST_OK},
    '{CMD_TAKE_FRONT, 32'h0,         5'd0,  1,  1'b0, 32'h0, 5'd0,  ST_OK},
    '{CMD_UNUSED_HI,  32'h1234_5678, 5'd16, 1,  1'b1, 32'h0, 5'd1,  ST_OK},
    '{CMD_CLEAR,      32'h0,         5'd0,  1,  1'b1, 32'h0, 5'd0,  ST_OK},
    '{CMD_ADD_BACK,   32'h0000_0100, 5'd0,  15, 1'b0, 32'h0, 5'd0,  ST_OK},
    '{CMD_ADD_FRONT,  32'hA5A5_A5A5, 5'd0,  1,  1'b1, 32'h0, 5'd16, ST_OK},
    '{CMD_ADD_BACK,   32'h5A5A_5A5A, 5'd0,  1,  1'b1, 32'h0, 5'd16, ST_FULL},
    '{CMD_INSERT,     32'h0,         5'd16, 1,  1'b1, 32'h0, 5'd16, ST_FULL},
    '{CMD_ADD_FRONT,  32'h0,         5'd0,  1,  1'b1, 32'h0, 5'd16, ST_FULL},
    '{CMD_READ_AT,    32'h0,         5'd15, 1,  1'b0, 32'h0, 5'd0,  ST_OK},
    '{CMD_READ_AT,    32'h0,         5'd16, 1,  1'b1, 32'h0, 5'd16, ST_RANGE},
    '{CMD_REMOVE,     32'h0,         5'd0,  1,  1'b1, 32'h0, 5'd15, ST_OK},
    '{CMD_READ_FRONT, 32'h0,         5'd0,  1,  1'b0, 32'h0, 5'd0,  ST_OK},
    '{CMD_INSERT,     32'h7FFF_FFFF, 5'd7,  1,  1'b0, 32'h0, 5'd0,  ST_OK},
    '{CMD_READ_AT,    32'h0,         5'd7,  1,  1'b0, 32'h0, 5'd0,  ST_OK}
  };

  initial begin : stimulus
    list_reply_t      reply;
    logic [CMD_W-1:0] cmd;
    logic [IN_W-1:0]  data;
    logic [IDX_W-1:0] idx;
    int               mode;
    int               roll;
    int               grow_pct;
    int               read_pct;
    reply.rd  = '0;
    reply.cnt = '0;
    reply.st  = ST_OK;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      reply.rd  = plan[r].rd;
      reply.cnt = plan[r].cnt;
      reply.st  = plan[r].st;
      for (int k = 0; k < plan[r].reps; k++)
        issue(plan[r].cmd, plan[r].data + k, plan[r].idx, plan[r].fixed, reply);
    end
    drain();

    mode = 0;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      // new command mix every hundred transfers; pause for a full drain now and then
      if (k % 100 == 0) begin
        mode = $urandom_range(0, 3);
        if (k % 400 == 0 && k != 0) drain();
      end
      allow_idle = !(k >= 700 && k < 1000);
      case (mode)
        0, 3:    begin grow_pct = 55; read_pct = 30; end
        1:       begin grow_pct = 20; read_pct = 30; end
        default: begin grow_pct = 35; read_pct = 35; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < grow_pct)
        cmd = CMD_W'($urandom_range(CMD_ADD_FRONT, CMD_INSERT));
      else if (roll < grow_pct + read_pct)
        cmd = CMD_W'($urandom_range(CMD_READ_FRONT, CMD_READ_AT));
      else if (roll < 97)
        cmd = CMD_W'($urandom_range(CMD_TAKE_FRONT, CMD_REMOVE));
      else if (roll < 98)
        cmd = CMD_CLEAR;
      else
        cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      case ($urandom_range(0, 9))
        0:       data = '0;
        1:       data = '1;
        default: data = $urandom;
      endcase
      // aim positions mostly inside the list, using the last reported count
      if ($urandom_range(0, 3) != 0 && !$isunknown(count_o))
        idx = IDX_W'($urandom_range(0, count_o));
      else
        idx = IDX_W'($urandom_range(0, CAPACITY));
      issue(cmd, data, idx, 1'b0, reply);
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) $display("indexed_list_engine_tb: PASS");
    else $display("indexed_list_engine_tb: FAIL");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS * 1ns);
    $display("indexed_list_engine_tb: FAIL");
    $finish;
  end

endmodule
